### design/mm4_pkg.sv
package mm4_pkg;

   // Field widths of the transaction payloads
   localparam int DATA_W = 32;
   localparam int IDX_W  = 4;
   localparam int PROD_W = 2 * DATA_W;

   // Saturation bounds of a result element
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Commands from the controller to the datapath
   typedef struct packed {
      logic wr_en;     // store one loaded element pair
      logic rd_en;     // read one term of the current dot product
      logic rd_first;  // this term starts a new dot product
      logic emit;      // move the finished sum into the output register
      logic last;      // the emitted element is the final one
   } mm4_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;  // output register is empty or drains this cycle
   } mm4_status_type;

endpackage

### design/mm4_ctrl.sv
module mm4_ctrl #(
   parameter int DIM = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mm4_pkg::mm4_status_type         status,
   output mm4_pkg::mm4_cmd_type            cmd,
   output logic [$clog2(DIM*DIM)-1:0]      wr_addr,
   output logic [$clog2(DIM*DIM)-1:0]      rd_left_addr,
   output logic [$clog2(DIM*DIM)-1:0]      rd_right_addr,
   output logic [$clog2(DIM*DIM)-1:0]      cell_idx
);
   import mm4_pkg::*;

   localparam int CELLS  = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);
   localparam int DIM_W  = $clog2(DIM);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  load_ff, load_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [DIM_W-1:0]   term_ff, term_in;
   logic               drain_ff, drain_in;
   logic               cell_last;
   logic               wr_fire;

   // Form the store addresses and the element index from the loop counters
   assign wr_addr       = load_ff;
   assign rd_left_addr  = CELL_W'(32'(row_ff) * DIM + 32'(term_ff));
   assign rd_right_addr = CELL_W'(32'(term_ff) * DIM + 32'(col_ff));
   assign cell_idx      = CELL_W'(32'(row_ff) * DIM + 32'(col_ff));
   assign cell_last     = (row_ff == DIM_W'(DIM - 1)) && (col_ff == DIM_W'(DIM - 1));

   assign req_ready = (state_ff == ST_LOAD);
   assign wr_fire   = req_valid && req_ready;

   // Decode commands and the next state
   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      term_in      = term_ff;
      drain_in     = drain_ff;
      cmd          = '0;
      cmd.wr_en    = wr_fire;
      cmd.rd_first = (term_ff == '0);
      cmd.last     = cell_last;
      unique case (state_ff)
         ST_LOAD: begin
            if (wr_fire) begin
               if (load_ff == CELL_W'(CELLS - 1)) begin
                  load_in  = '0;
                  row_in   = '0;
                  col_in   = '0;
                  term_in  = '0;
                  state_in = ST_READ;
               end else begin
                  load_in = load_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (term_ff == DIM_W'(DIM - 1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait for the read and multiply stages to empty
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               term_in  = '0;
               if (cell_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
                  if (col_ff == DIM_W'(DIM - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         load_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         term_ff  <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         term_ff  <= term_in;
         drain_ff <= drain_in;
      end
   end

endmodule

### design/mm4_dpath.sv
module mm4_dpath #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mm4_pkg::mm4_cmd_type               cmd,
   input  logic [$clog2(DIM*DIM)-1:0]         wr_addr,
   input  logic [$clog2(DIM*DIM)-1:0]         rd_left_addr,
   input  logic [$clog2(DIM*DIM)-1:0]         rd_right_addr,
   input  logic [$clog2(DIM*DIM)-1:0]         cell_idx,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_value,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_value,
   output mm4_pkg::mm4_status_type            status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_product_value,
   output logic [mm4_pkg::IDX_W-1:0]          rsp_element_index,
   output logic                               rsp_last
);
   import mm4_pkg::*;

   localparam int CELLS = DIM * DIM;
   localparam int ACC_W = PROD_W + $clog2(DIM);
   localparam int TOP_L = FRAC_BITS + DATA_W - 1;

   logic [DATA_W-1:0]        left_mem  [CELLS];
   logic [DATA_W-1:0]        right_mem [CELLS];
   logic [DATA_W-1:0]        left_q_ff, right_q_ff;
   logic                     rd_valid_ff, rd_first_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff, prod_first_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic [ACC_W-1:TOP_L]     acc_top;
   logic [DATA_W-1:0]        sat_value;
   logic                     out_valid_ff;
   logic [DATA_W-1:0]        out_value_ff;
   logic [IDX_W-1:0]         out_index_ff;
   logic                     out_last_ff;

   // Write loaded pairs and read one term per cycle while cmd.rd_en is set
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         left_mem[wr_addr]  <= req_left_value;
         right_mem[wr_addr] <= req_right_value;
      end
      if (cmd.rd_en) begin
         left_q_ff  <= left_mem[rd_left_addr];
         right_q_ff <= right_mem[rd_right_addr];
      end
   end

   // Multiply one term at full width
   assign prod_in = $signed(left_q_ff) * $signed(right_q_ff);

   // Accumulate exactly, restart on the first term
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = prod_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      prod_first_ff <= rd_first_ff;
      rd_first_ff   <= cmd.rd_first;
      if (rd_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Drop fraction bits by floor and clamp to the output range
   assign acc_top   = acc_ff[ACC_W-1:TOP_L];
   assign sat_value = ((&acc_top) || !(|acc_top)) ? acc_ff[TOP_L:FRAC_BITS]
                    : (acc_ff[ACC_W-1] ? SAT_MIN : SAT_MAX);

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff <= sat_value;
         out_index_ff <= IDX_W'(cell_idx);
         out_last_ff  <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.rd_en;
         prod_valid_ff <= rd_valid_ff;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid         = out_valid_ff;
   assign rsp_product_value = out_value_ff;
   assign rsp_element_index = out_index_ff;
   assign rsp_last          = out_last_ff;

endmodule

### design/matrix4x4_multiply.sv
// Fixed-point matrix product, DIM x DIM, signed Q(31-FRAC_BITS).FRAC_BITS.
// Input channel req_*: one transaction per element pair, left and right at
// the same row-major index, sent in index order. Every DIM*DIM-th
// transaction completes a load and starts the product.
// Result channel rsp_*: DIM*DIM transactions in row-major order, each with
// its element index; rsp_last marks the final element.
// Loading accepts one transaction per cycle. Each result element runs DIM
// reads through one shared multiply-accumulate unit, then waits in a drain
// state until the read and multiply stages are empty before it is emitted.
// The single read port of each store and the shared multiplier set the pace.
// req_ready is low while a product is computed; loading of the next pair of
// matrices starts as soon as the final result enters the output register.
// A stalled receiver holds the output register and stops the computation
// before the next element is emitted; nothing is dropped.
// Reset clears the load count and all control state; the stores hold no
// data worth keeping until a full load has been written.
module matrix4x4_multiply #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_value,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_product_value,
   output logic [mm4_pkg::IDX_W-1:0]          rsp_element_index,
   output logic                               rsp_last
);
   import mm4_pkg::*;

   localparam int CELL_W = $clog2(DIM * DIM);

   mm4_cmd_type       cmd;
   mm4_status_type    status;
   logic [CELL_W-1:0] wr_addr;
   logic [CELL_W-1:0] rd_left_addr;
   logic [CELL_W-1:0] rd_right_addr;
   logic [CELL_W-1:0] cell_idx;

   mm4_ctrl #(
      .DIM (DIM)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .cell_idx      (cell_idx)
   );

   mm4_dpath #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .wr_addr           (wr_addr),
      .rd_left_addr      (rd_left_addr),
      .rd_right_addr     (rd_right_addr),
      .cell_idx          (cell_idx),
      .req_left_value    (req_left_value),
      .req_right_value   (req_right_value),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_value (rsp_product_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last)
   );

endmodule

### design/mm4_check.sv
module mm4_check #(
   parameter int DIM = 4
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [mm4_pkg::DATA_W-1:0]  rsp_product_value,
   input logic [mm4_pkg::IDX_W-1:0]          rsp_element_index,
   input logic                               rsp_last
);
   import mm4_pkg::*;

   localparam int CELLS = DIM * DIM;

   // Hold a stalled result transaction unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_value)
         && $stable(rsp_element_index) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   // The final element is not followed directly by another result
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result appeared right after the final element");

   // Loading is closed while an inner element is pending
   a_no_load_midway: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken while a product is being emitted");

   // The final element carries the last index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_element_index == IDX_W'(CELLS - 1))
      else $error("final element has the wrong index");

endmodule

bind matrix4x4_multiply mm4_check #(
   .DIM (DIM)
) u_mm4_check (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_product_value (rsp_product_value),
   .rsp_element_index (rsp_element_index),
   .rsp_last          (rsp_last)
);

### bench/matrix4x4_multiply_check.sv
// Watch both channels, predict every product element and compare it.
module matrix4x4_multiply_check #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_value,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [mm4_pkg::DATA_W-1:0]  rsp_product_value,
   input  logic [mm4_pkg::IDX_W-1:0]          rsp_element_index,
   input  logic                               rsp_last,
   output int                                 mismatch_count,
   output int                                 outstanding,
   output int                                 elements_checked,
   output int                                 saturated_count
);

   import mm4_pkg::*;

   localparam int CELLS = DIM * DIM;
   // Four full-width products need two extra bits, more for larger DIM
   localparam int ACC_W = 2 * DATA_W + $clog2(DIM) + 1;
   localparam logic signed [ACC_W-1:0] TOP_LIMIT    = (ACC_W'(1) <<< (DATA_W-1)) - 1;
   localparam logic signed [ACC_W-1:0] BOTTOM_LIMIT = -(ACC_W'(1) <<< (DATA_W-1));

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  index;
      logic              last;
   } product_element_type;

   logic signed [DATA_W-1:0] left_matrix  [CELLS];
   logic signed [DATA_W-1:0] right_matrix [CELLS];
   int                       elements_loaded;
   product_element_type      product_q [$];

   // Form one exact dot product, floor it to the output format and clamp it
   function automatic logic [DATA_W-1:0] dot_product(int row, int col);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] term;
      acc = '0;
      for (int e = 0; e < DIM; e++) begin
         term = left_matrix[row*DIM+e] * right_matrix[e*DIM+col];
         acc += term;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > TOP_LIMIT)
         return SAT_MAX;
      if (acc < BOTTOM_LIMIT)
         return SAT_MIN;
      return acc[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      product_element_type want;
      product_element_type got;
      if (reset) begin
         elements_loaded = 0;
         product_q.delete();
      end else begin
         // Store each accepted element pair; a full load yields the product
         if (req_valid && req_ready) begin
            left_matrix[elements_loaded]  = req_left_value;
            right_matrix[elements_loaded] = req_right_value;
            elements_loaded++;
            if (elements_loaded == CELLS) begin
               elements_loaded = 0;
               for (int row = 0; row < DIM; row++) begin
                  for (int col = 0; col < DIM; col++) begin
                     want.value = dot_product(row, col);
                     want.index = IDX_W'(row * DIM + col);
                     want.last  = (row * DIM + col == CELLS - 1);
                     if (want.value == SAT_MAX || want.value == SAT_MIN)
                        saturated_count++;
                     product_q.push_back(want);
                  end
               end
            end
         end

         // Compare each result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.value = rsp_product_value;
            got.index = rsp_element_index;
            got.last  = rsp_last;
            if (product_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, value %h index %0d last %0b",
                        $realtime, got.value, got.index, got.last);
            end else begin
               want = product_q.pop_front();
               elements_checked++;
               if (got.value !== want.value) begin
                  mismatch_count++;
                  $display("%0t: element %0d value expected %h, actual %h",
                           $realtime, want.index, want.value, got.value);
               end
               if (got.index !== want.index) begin
                  mismatch_count++;
                  $display("%0t: element index expected %0d, actual %0d",
                           $realtime, want.index, got.index);
               end
               if (got.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: element %0d last expected %0b, actual %0b",
                           $realtime, want.index, want.last, got.last);
               end
            end
         end
      end
      outstanding = product_q.size();
   end

endmodule

### bench/matrix4x4_multiply_test.sv
module matrix4x4_multiply_test;

   import mm4_pkg::*;

   localparam int DIM          = 4;
   localparam int FRAC_BITS    = 16;
   localparam int CELLS        = DIM * DIM;
   localparam int RANDOM_LOADS = 16;
   localparam int MAX_WAIT     = 12;
   localparam int TAIL_CYCLES  = 30;
   localparam int LIMIT_CYCLES = 200000;

   // How the elements of one random matrix pair are drawn
   typedef enum int {
      ANY_BITS,
      SMALL_FIXED,
      MID_FIXED,
      CORNER_VALUES,
      MIXED_FILL
   } fill_style_type;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_left_value  = '0;
   logic signed [DATA_W-1:0] req_right_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic signed [DATA_W-1:0] rsp_product_value;
   logic [IDX_W-1:0]         rsp_element_index;
   logic                     rsp_last;

   int mismatch_count;
   int outstanding;
   int elements_checked;
   int saturated_count;
   int cycle_count;
   int rsp_hold;

   // Directed load: rows and columns of extremes, sign flips, floor cases
   logic [DATA_W-1:0] corner_left [CELLS] = '{
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      32'hFFFFFFFF, 32'hFFFF0000, 32'h00010000, 32'h00000000,
      32'h00018000, 32'h00000001, 32'hFFFD8000, 32'h55555555
   };
   logic [DATA_W-1:0] corner_right [CELLS] = '{
      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hAAAAAAAA
   };

   initial begin
      forever #10 clock = ~clock;
   end

   matrix4x4_multiply #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_value    (req_left_value),
      .req_right_value   (req_right_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_value (rsp_product_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last)
   );

   matrix4x4_multiply_check #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) product_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_value    (req_left_value),
      .req_right_value   (req_right_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_value (rsp_product_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .elements_checked  (elements_checked),
      .saturated_count   (saturated_count)
   );

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Run timed out after %0d cycles, %0d results still expected",
                  cycle_count, outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stall the result channel for a random number of cycles after each
   // transaction; switch to stall-free stretches now and then
   always @(posedge clock) begin : rsp_pacing
      int unsigned hold;
      bit          no_stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 19) == 0)
            no_stall = ~no_stall;
         hold = no_stall ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_hold  <= hold;
         rsp_ready <= (hold == 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold  <= 0;
         rsp_ready <= 1'b1;
      end
   end

   // Draw one matrix element in the given style
   function automatic logic [DATA_W-1:0] pick_element(fill_style_type style);
      fill_style_type kind;
      kind = (style == MIXED_FILL) ? fill_style_type'($urandom_range(0, 3)) : style;
      case (kind)
         SMALL_FIXED: return $urandom_range(0, 1 << 20) - (1 << 19);
         MID_FIXED:   return $urandom_range(0, 1 << 25) - (1 << 24);
         CORNER_VALUES: begin
            case ($urandom_range(0, 5))
               0:       return SAT_MAX;
               1:       return SAT_MIN;
               2:       return '0;
               3:       return '1;
               4:       return 32'h00010000;
               default: return 32'hFFFF0000;
            endcase
         end
         default:     return $urandom;
      endcase
   endfunction

   // Send one element pair after an idle gap and hold it until accepted
   task automatic send_pair(input logic [DATA_W-1:0] left, input logic [DATA_W-1:0] right,
                            input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_left_value  <= left;
      req_right_value <= right;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : stimulus
      fill_style_type style;
      bit             no_gaps;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed load first
      for (int i = 0; i < CELLS; i++)
         send_pair(corner_left[i], corner_right[i], $urandom_range(0, MAX_WAIT));

      // Random loads, some of them without idle gaps
      for (int m = 0; m < RANDOM_LOADS; m++) begin
         style   = fill_style_type'($urandom_range(0, 4));
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < CELLS; i++)
            send_pair(pick_element(style), pick_element(style),
                      no_gaps ? 0 : $urandom_range(0, MAX_WAIT));
      end
      req_valid <= 1'b0;

      // Drain the remaining results, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d matrix products from %0d element pairs under random stalls:",
               RANDOM_LOADS + 1, (RANDOM_LOADS + 1) * CELLS);
      $display("%0d result elements checked, %0d of them at a saturation bound",
               elements_checked, saturated_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
